[design/rrdtpp_pkg.sv]
// shared constants and types of the round-robin due-time poll picker
package rrdtpp_pkg;

   localparam int ENTRIES  = 256;
   localparam int IDX_W    = $clog2(ENTRIES);
   localparam int CNT_W    = $clog2(ENTRIES + 1);
   localparam int SCAN_W   = 8;
   localparam int PERIOD_W = 16;
   localparam int TICK_W   = 14;
   localparam int TIME_W   = 32;
   localparam int PROD_W   = PERIOD_W + TICK_W;
   localparam int NUM_W    = PROD_W + 1;
   localparam int DIVISOR  = 1000;
   localparam int ROUND_ADD = 999;
   localparam int TICK_RESET = 1000;

   // divide by 1000 as a shift by 3 and a reciprocal multiply for the odd part 125
   localparam int PRE_SHIFT   = 3;
   localparam int ODD_DIV     = DIVISOR >> PRE_SHIFT;
   localparam int DIVQ_W      = NUM_W - PRE_SHIFT;
   localparam int RECIP_SHIFT = DIVQ_W + $clog2(ODD_DIV);
   localparam int RECIP_W     = DIVQ_W + 1;
   localparam longint RECIP_M = ((longint'(1) << RECIP_SHIFT) + longint'(ODD_DIV) - 1) /
                                longint'(ODD_DIV);
   localparam int MUL_A_W     = DIVQ_W;
   localparam int MUL_B_W     = RECIP_W;
   localparam int MUL_P_W     = MUL_A_W + MUL_B_W;

   localparam logic [RECIP_W-1:0]    RECIP_V      = RECIP_W'(RECIP_M);
   localparam logic [NUM_W-1:0]      ROUND_V      = ROUND_ADD[NUM_W-1:0];
   localparam logic [TICK_W-1:0]     TICK_RESET_V = TICK_RESET[TICK_W-1:0];
   localparam logic [CNT_W-1:0]      ENTRIES_CNT  = CNT_W'(ENTRIES);
   localparam logic [IDX_W-1:0]      LAST_IDX     = IDX_W'(ENTRIES - 1);

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_POLL = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_MULT  = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_WRITE = 5'b10000
   } state_type;

endpackage

[design/rrdtpp_ram.sv]
// generic single write port ram with registered read
module rrdtpp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/round_robin_due_time_poll_picker_unit.sv]
// round-robin due-time poll picker: entry table, scan sequencer and reschedule divider
//
// Input channel: an item is taken at a clock edge with start high and busy low.
// req_mode low loads one table entry (period, source bit, next-due = req_now_tick).
// req_mode high asks for the next due entry, scanning from the round-robin cursor.
// Result channel: every item gives exactly one result, shown for one cycle with
// rsp_strobe high; rsp_granted and rsp_selected_index carry it.
// Configuration: csr_write_enable writes csr_write_data into tick_rate (ticks/s).
// A load gives its result in the next cycle and busy stays low.
// A poll reads one entry per cycle through the table memories, whose read is
// registered; a hit goes on to the shared multiplier for period times tick rate,
// then to the same multiplier to divide by 1000 through a reciprocal, then to
// a write-back of the new next-due time. A miss ends once every entry is checked.
// busy is high for the whole poll; the next item may start in the result cycle.
// Reset clears the active marks, the cursor and the result strobe and loads
// tick_rate with 1000; the period and next-due memories are not cleared.
// The receiver cannot hold off results, so nothing waits on the output side.
module round_robin_due_time_poll_picker_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_mode,
   input  logic [7:0]                         req_entry_index,
   input  logic [rrdtpp_pkg::PERIOD_W-1:0]    req_period_ms,
   input  logic                               req_source_present,
   input  logic [rrdtpp_pkg::TIME_W-1:0]      req_now_tick,
   input  logic                               csr_write_enable,
   input  logic [rrdtpp_pkg::TICK_W-1:0]      csr_write_data,
   output logic                               rsp_strobe,
   output logic                               rsp_granted,
   output logic [rrdtpp_pkg::SCAN_W-1:0]      rsp_selected_index
);

   rrdtpp_pkg::state_type state_ff, state_in;

   logic [rrdtpp_pkg::TICK_W-1:0]   tick_rate_ff;
   logic [rrdtpp_pkg::SCAN_W-1:0]   scan_start_ff, scan_start_in;
   logic [rrdtpp_pkg::IDX_W-1:0]    ptr_ff, ptr_in;
   logic [rrdtpp_pkg::CNT_W-1:0]    iss_cnt_ff, iss_cnt_in;
   logic                            rd_vld_ff, rd_vld_in;
   logic                            rd_act_ff, rd_act_in;
   logic [rrdtpp_pkg::IDX_W-1:0]    rd_idx_ff, rd_idx_in;
   logic [rrdtpp_pkg::IDX_W-1:0]    sel_idx_ff, sel_idx_in;
   logic [rrdtpp_pkg::PERIOD_W-1:0] period_ff, period_in;
   logic [rrdtpp_pkg::TIME_W-1:0]   now_ff, now_in;
   logic [rrdtpp_pkg::NUM_W-1:0]    quo_ff, quo_in;
   logic                            rsp_strobe_ff, rsp_strobe_in;
   logic                            rsp_granted_ff, rsp_granted_in;
   logic [rrdtpp_pkg::SCAN_W-1:0]   rsp_index_ff, rsp_index_in;
   logic                            active_ff [rrdtpp_pkg::ENTRIES];

   logic                            accept;
   logic                            load_wr;
   logic [rrdtpp_pkg::IDX_W-1:0]    load_addr;
   logic                            issue;
   logic                            due;
   logic [rrdtpp_pkg::TIME_W-1:0]   diff;
   logic [rrdtpp_pkg::MUL_A_W-1:0]  mul_a;
   logic [rrdtpp_pkg::MUL_B_W-1:0]  mul_b;
   logic [rrdtpp_pkg::MUL_P_W-1:0]  mul_p;
   logic [rrdtpp_pkg::IDX_W-1:0]    scan_next;
   logic                            nd_wr_en;
   logic [rrdtpp_pkg::IDX_W-1:0]    nd_wr_addr;
   logic [rrdtpp_pkg::TIME_W-1:0]   nd_wr_data;
   logic [rrdtpp_pkg::PERIOD_W-1:0] period_rd;
   logic [rrdtpp_pkg::TIME_W-1:0]   next_due_rd;

   assign busy      = (state_ff != rrdtpp_pkg::ST_IDLE);
   assign accept    = start && !busy;
   assign load_addr = rrdtpp_pkg::IDX_W'(req_entry_index);
   // loads beyond a short table are dropped
   assign load_wr   = accept && (req_mode == rrdtpp_pkg::MODE_LOAD) &&
                      (32'(req_entry_index) < 32'(rrdtpp_pkg::ENTRIES));

   assign issue  = (iss_cnt_ff != rrdtpp_pkg::ENTRIES_CNT);
   assign diff   = now_ff - next_due_rd;
   // wrap-safe due test on the signed difference
   assign due    = rd_vld_ff && rd_act_ff && !diff[rrdtpp_pkg::TIME_W-1];

   // one multiplier: period times tick rate, then the rounded sum shifted by 3 times 1/125
   assign mul_a  = (state_ff == rrdtpp_pkg::ST_DIV) ?
                   quo_ff[rrdtpp_pkg::NUM_W-1:rrdtpp_pkg::PRE_SHIFT] :
                   rrdtpp_pkg::MUL_A_W'(period_ff);
   assign mul_b  = (state_ff == rrdtpp_pkg::ST_DIV) ? rrdtpp_pkg::RECIP_V :
                   rrdtpp_pkg::MUL_B_W'(tick_rate_ff);
   assign mul_p  = rrdtpp_pkg::MUL_P_W'(mul_a) * rrdtpp_pkg::MUL_P_W'(mul_b);
   assign scan_next = (sel_idx_ff == rrdtpp_pkg::LAST_IDX) ? '0 : sel_idx_ff + 1'b1;

   // one write port on the next-due memory: loads when idle, reschedule otherwise
   assign nd_wr_addr = load_wr ? load_addr : sel_idx_ff;
   assign nd_wr_data = load_wr ? req_now_tick : now_ff + rrdtpp_pkg::TIME_W'(quo_ff);

   rrdtpp_ram #(
      .WIDTH (rrdtpp_pkg::PERIOD_W),
      .DEPTH (rrdtpp_pkg::ENTRIES)
   ) u_period_ram (
      .clock   (clock),
      .wr_en   (load_wr),
      .wr_addr (load_addr),
      .wr_data (req_period_ms),
      .rd_addr (ptr_ff),
      .rd_data (period_rd)
   );

   rrdtpp_ram #(
      .WIDTH (rrdtpp_pkg::TIME_W),
      .DEPTH (rrdtpp_pkg::ENTRIES)
   ) u_next_due_ram (
      .clock   (clock),
      .wr_en   (load_wr || nd_wr_en),
      .wr_addr (nd_wr_addr),
      .wr_data (nd_wr_data),
      .rd_addr (ptr_ff),
      .rd_data (next_due_rd)
   );

   always_comb begin
      state_in       = state_ff;
      ptr_in         = ptr_ff;
      iss_cnt_in     = iss_cnt_ff;
      rd_vld_in      = 1'b0;
      rd_act_in      = rd_act_ff;
      rd_idx_in      = rd_idx_ff;
      sel_idx_in     = sel_idx_ff;
      period_in      = period_ff;
      now_in         = now_ff;
      quo_in         = quo_ff;
      scan_start_in  = scan_start_ff;
      rsp_strobe_in  = 1'b0;
      rsp_granted_in = 1'b0;
      rsp_index_in   = '0;
      nd_wr_en       = 1'b0;
      unique case (state_ff)
         rrdtpp_pkg::ST_IDLE: begin
            if (accept) begin
               now_in = req_now_tick;
               if (req_mode == rrdtpp_pkg::MODE_POLL) begin
                  state_in   = rrdtpp_pkg::ST_SCAN;
                  ptr_in     = rrdtpp_pkg::IDX_W'(scan_start_ff);
                  iss_cnt_in = '0;
               end else begin
                  rsp_strobe_in = 1'b1;
               end
            end
         end
         rrdtpp_pkg::ST_SCAN: begin
            if (issue) begin
               ptr_in     = (ptr_ff == rrdtpp_pkg::LAST_IDX) ? '0 : ptr_ff + 1'b1;
               iss_cnt_in = iss_cnt_ff + 1'b1;
               rd_vld_in  = 1'b1;
               rd_act_in  = active_ff[ptr_ff];
               rd_idx_in  = ptr_ff;
            end
            if (due) begin
               sel_idx_in = rd_idx_ff;
               period_in  = period_rd;
               rd_vld_in  = 1'b0;
               state_in   = rrdtpp_pkg::ST_MULT;
            end else if (rd_vld_ff && !issue) begin
               // last entry checked, nothing due
               state_in      = rrdtpp_pkg::ST_IDLE;
               rsp_strobe_in = 1'b1;
            end
         end
         rrdtpp_pkg::ST_MULT: begin
            quo_in   = rrdtpp_pkg::NUM_W'(mul_p) + rrdtpp_pkg::ROUND_V;
            state_in = rrdtpp_pkg::ST_DIV;
         end
         rrdtpp_pkg::ST_DIV: begin
            // drop the factor 8 by the shift, the factor 125 by the reciprocal
            quo_in   = rrdtpp_pkg::NUM_W'(mul_p >> rrdtpp_pkg::RECIP_SHIFT);
            state_in = rrdtpp_pkg::ST_WRITE;
         end
         rrdtpp_pkg::ST_WRITE: begin
            nd_wr_en       = 1'b1;
            scan_start_in  = rrdtpp_pkg::SCAN_W'(scan_next);
            rsp_strobe_in  = 1'b1;
            rsp_granted_in = 1'b1;
            rsp_index_in   = rrdtpp_pkg::SCAN_W'(sel_idx_ff);
            state_in       = rrdtpp_pkg::ST_IDLE;
         end
         default: begin
            state_in = rrdtpp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rrdtpp_pkg::ST_IDLE;
         tick_rate_ff  <= rrdtpp_pkg::TICK_RESET_V;
         scan_start_ff <= '0;
         iss_cnt_ff    <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < rrdtpp_pkg::ENTRIES; i++) begin
            active_ff[i] <= 1'b0;
         end
      end else begin
         state_ff      <= state_in;
         scan_start_ff <= scan_start_in;
         iss_cnt_ff    <= iss_cnt_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_write_enable) begin
            tick_rate_ff <= csr_write_data;
         end
         if (load_wr) begin
            active_ff[load_addr] <= req_source_present && (req_period_ms != '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff         <= ptr_in;
      rd_act_ff      <= rd_act_in;
      rd_idx_ff      <= rd_idx_in;
      sel_idx_ff     <= sel_idx_in;
      period_ff      <= period_in;
      now_ff         <= now_in;
      quo_ff         <= quo_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_index_ff   <= rsp_index_in;
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_granted        = rsp_granted_ff;
   assign rsp_selected_index = rsp_index_ff;

endmodule

[design/rrdtpp_checker.sv]
// port-level checks for the round-robin due-time poll picker
module rrdtpp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            req_mode,
   input logic                            rsp_strobe,
   input logic                            rsp_granted,
   input logic [rrdtpp_pkg::SCAN_W-1:0]   rsp_selected_index
);

   // a load item answers in the next cycle with no grant
   a_load_answers: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_mode == rrdtpp_pkg::MODE_LOAD) |=> rsp_strobe && !rsp_granted)
      else $error("load item did not answer in the next cycle");

   // a poll item keeps the block busy
   a_poll_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_mode == rrdtpp_pkg::MODE_POLL) |=> busy && !rsp_strobe)
      else $error("poll item did not hold busy");

   // the block ends a poll only by giving its result
   a_end_with_result: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> rsp_strobe)
      else $error("poll finished without a result");

   // a result never shows while work is still going on
   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while busy");

   // no grant reports index zero
   a_miss_index: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_granted |-> (rsp_selected_index == '0))
      else $error("nonzero index without a grant");

endmodule

bind round_robin_due_time_poll_picker_unit rrdtpp_checker u_rrdtpp_checker (.*);
